[rtl/sha_pkg.sv]
package sha_pkg;

    localparam int ID_W    = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    granted_id;
        t_status            status;
        logic               is_allocated;
        logic [COUNT_W-1:0] slot_count;
        logic [COUNT_W-1:0] allocated_count;
    } t_result;

endpackage

[rtl/sha_ram.sv]
// Simple dual-port memory: one write port, one read port, registered read data.
// No reset: every read the control logic trusts was written first.
module sha_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sha_exec.sv]
// Decision logic for one registered request. It sees the valid bit of the
// addressed slot and the entry on top of the free stack, both already
// corrected for a write by the previous request, and produces the next
// counters, the memory writes and the result.
module sha_exec #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                             i_valid,
    input  sha_pkg::t_func                   i_func,
    input  logic [sha_pkg::ID_W-1:0]         i_slot_id,
    input  logic                             i_vm_bit,
    input  logic [$clog2(NUM_SLOTS)-1:0]     i_fs_top,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   i_free_depth,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]   i_created,
    output logic [$clog2(NUM_SLOTS+1)-1:0]   o_free_depth,
    output logic [$clog2(NUM_SLOTS+1)-1:0]   o_created,
    output logic                             o_vm_we,
    output logic [$clog2(NUM_SLOTS)-1:0]     o_vm_waddr,
    output logic                             o_vm_wdata,
    output logic                             o_fs_we,
    output logic [$clog2(NUM_SLOTS)-1:0]     o_fs_waddr,
    output logic [$clog2(NUM_SLOTS)-1:0]     o_fs_wdata,
    output sha_pkg::t_result                 o_result
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = ((CNT_W > sha_pkg::ID_W) ? CNT_W : sha_pkg::ID_W) + 1;

    logic [CMP_W-1:0] sid_ext;
    logic [CMP_W-1:0] created_ext;
    logic             in_range;
    logic             slot_live;

    // A slot at or above the high-water mark was never handed out, so its
    // memory entry is stale and is ignored.
    assign sid_ext     = CMP_W'(i_slot_id);
    assign created_ext = CMP_W'(i_created);
    assign in_range    = (sid_ext < created_ext) && (sid_ext < CMP_W'(NUM_SLOTS));
    assign slot_live   = in_range && i_vm_bit;

    always_comb begin
        o_free_depth             = i_free_depth;
        o_created                = i_created;
        o_vm_we                  = 1'b0;
        o_vm_waddr               = IDX_W'(i_slot_id);
        o_vm_wdata               = 1'b0;
        o_fs_we                  = 1'b0;
        o_fs_waddr               = i_free_depth[IDX_W-1:0];
        o_fs_wdata               = IDX_W'(i_slot_id);
        o_result.granted_id      = '0;
        o_result.status          = sha_pkg::ST_OK;
        o_result.is_allocated    = 1'b0;

        if (i_valid) begin
            case (i_func)
                sha_pkg::FUNC_ALLOC: begin
                    if (i_free_depth != '0) begin
                        // Reuse the most recently freed slot.
                        o_free_depth        = i_free_depth - 1'b1;
                        o_vm_we             = 1'b1;
                        o_vm_waddr          = i_fs_top;
                        o_vm_wdata          = 1'b1;
                        o_result.granted_id = sha_pkg::ID_W'(i_fs_top);
                    end else if (i_created < CNT_W'(NUM_SLOTS)) begin
                        o_created           = i_created + 1'b1;
                        o_vm_we             = 1'b1;
                        o_vm_waddr          = i_created[IDX_W-1:0];
                        o_vm_wdata          = 1'b1;
                        o_result.granted_id = sha_pkg::ID_W'(i_created);
                    end else begin
                        o_result.status = sha_pkg::ST_FULL;
                    end
                end
                sha_pkg::FUNC_FREE: begin
                    if (slot_live && (i_free_depth < CNT_W'(NUM_SLOTS))) begin
                        o_free_depth = i_free_depth + 1'b1;
                        o_vm_we      = 1'b1;
                        o_vm_wdata   = 1'b0;
                        o_fs_we      = 1'b1;
                    end else begin
                        o_result.status = sha_pkg::ST_BAD_FREE;
                    end
                end
                sha_pkg::FUNC_QUERY: begin
                    o_result.is_allocated = slot_live;
                end
                default: begin
                end
            endcase
        end

        o_result.slot_count      = sha_pkg::COUNT_W'(o_created);
        o_result.allocated_count = sha_pkg::COUNT_W'(o_created - o_free_depth);
    end

endmodule

[rtl/slot_handle_allocator_unit.sv]
// Channel   | Direction | Ports                                  | Handshake
// ----------+-----------+----------------------------------------+----------------------------
// request   | in        | i_func, i_slot_id                      | start high, busy low
// result    | out       | o_granted_id, o_status, o_is_allocated,| o_valid high for one cycle
//           |           | o_slot_count, o_allocated_count        |
//
// A request is accepted whenever busy is low; busy is high during reset and
// in the first cycle after reset is released. Each request gives one result
// through the request and result registers; a new request can follow every cycle.
// The result register cannot be stalled, so o_valid lasts exactly one cycle.
// Reset is synchronous and active low. It clears the counters and the
// pipeline valid flags and raises busy; no clearing pass over the memories
// is needed, so the unit takes requests as soon as busy falls.
//
// Structure: at the accepting edge the request is registered and both
// memories are read (the valid bit of the named slot and the free-stack
// entry just below the stack depth left by the request in flight). In the
// next cycle the decision logic works on those registered values and
// commits the counters, the memory writes and the result register.
// Because the read for a request is launched while the previous request
// writes, a read whose address matches that write takes the written data
// through a registered bypass instead of the stale memory word.
//
// The valid map holds no reset value: an entry at or above the slot count
// was never handed out and is treated as free whatever its memory word
// holds, and every entry below it was set when its slot was first created.
module slot_handle_allocator_unit #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_func,
    input  logic [sha_pkg::ID_W-1:0]         i_slot_id,
    output logic                             o_valid,
    output logic [sha_pkg::ID_W-1:0]         o_granted_id,
    output logic [1:0]                       o_status,
    output logic                             o_is_allocated,
    output logic [sha_pkg::COUNT_W-1:0]      o_slot_count,
    output logic [sha_pkg::COUNT_W-1:0]      o_allocated_count
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic                     accept;

    // Request stage.
    logic                     r_busy;
    logic                     r_req_valid;
    sha_pkg::t_func           r_func;
    logic [sha_pkg::ID_W-1:0] r_slot_id;
    logic                     r_vm_byp;
    logic                     r_vm_byp_d;
    logic                     r_fs_byp;
    logic [IDX_W-1:0]         r_fs_byp_d;

    // Allocator state.
    logic [CNT_W-1:0]         r_free_depth;
    logic [CNT_W-1:0]         r_created;
    logic [CNT_W-1:0]         n_free_depth;
    logic [CNT_W-1:0]         n_created;
    logic [CNT_W-1:0]         n_depth_m1;

    // Result stage.
    logic                     r_out_valid;
    sha_pkg::t_result         r_result;
    sha_pkg::t_result         n_result;

    // Memory ports.
    logic                     vm_we;
    logic [IDX_W-1:0]         vm_waddr;
    logic                     vm_wdata;
    logic [IDX_W-1:0]         vm_raddr;
    logic                     vm_rdata;
    logic                     fs_we;
    logic [IDX_W-1:0]         fs_waddr;
    logic [IDX_W-1:0]         fs_wdata;
    logic [IDX_W-1:0]         fs_raddr;
    logic [IDX_W-1:0]         fs_rdata;
    logic                     vm_bit;
    logic [IDX_W-1:0]         fs_top;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // Read addresses follow the state as it will be after the request now
    // in the decision stage has been committed.
    assign n_depth_m1 = n_free_depth - 1'b1;
    assign vm_raddr   = IDX_W'(i_slot_id);
    assign fs_raddr   = n_depth_m1[IDX_W-1:0];

    assign vm_bit = r_vm_byp ? r_vm_byp_d : vm_rdata;
    assign fs_top = r_fs_byp ? r_fs_byp_d : fs_rdata;

    sha_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS)
    ) u_valid_map (
        .i_clk   (i_clk),
        .i_we    (vm_we),
        .i_waddr (vm_waddr),
        .i_wdata (vm_wdata),
        .i_raddr (vm_raddr),
        .o_rdata (vm_rdata)
    );

    sha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_SLOTS)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    sha_exec #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_exec (
        .i_valid      (r_req_valid),
        .i_func       (r_func),
        .i_slot_id    (r_slot_id),
        .i_vm_bit     (vm_bit),
        .i_fs_top     (fs_top),
        .i_free_depth (r_free_depth),
        .i_created    (r_created),
        .o_free_depth (n_free_depth),
        .o_created    (n_created),
        .o_vm_we      (vm_we),
        .o_vm_waddr   (vm_waddr),
        .o_vm_wdata   (vm_wdata),
        .o_fs_we      (fs_we),
        .o_fs_waddr   (fs_waddr),
        .o_fs_wdata   (fs_wdata),
        .o_result     (n_result)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_req_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_free_depth <= '0;
            r_created    <= '0;
        end else begin
            r_busy       <= 1'b0;
            r_req_valid  <= accept;
            r_out_valid  <= r_req_valid;
            r_free_depth <= n_free_depth;
            r_created    <= n_created;
        end
    end

    // Payload registers, including the read bypass captured with the request.
    always_ff @(posedge i_clk) begin
        r_func     <= sha_pkg::t_func'(i_func);
        r_slot_id  <= i_slot_id;
        r_vm_byp   <= vm_we && (vm_waddr == vm_raddr);
        r_vm_byp_d <= vm_wdata;
        r_fs_byp   <= fs_we && (fs_waddr == fs_raddr);
        r_fs_byp_d <= fs_wdata;
        r_result   <= n_result;
    end

    assign o_valid           = r_out_valid;
    assign o_granted_id      = r_result.granted_id;
    assign o_status          = r_result.status;
    assign o_is_allocated    = r_result.is_allocated;
    assign o_slot_count      = r_result.slot_count;
    assign o_allocated_count = r_result.allocated_count;

`ifndef ASSERT_OFF
    // Every accepted request produces its result through the request and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("accepted request produced no result");

    // The free stack can never hold more slots than were ever created.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_depth <= r_created)
        else $error("free stack deeper than slot count");

    // A granted handle always lies below the slot count it reports.
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && (r_func == sha_pkg::FUNC_ALLOC) &&
         (n_result.status == sha_pkg::ST_OK))
        |-> (CNT_W'(n_result.granted_id) < n_created) || (CNT_W > sha_pkg::ID_W))
        else $error("granted handle beyond slot count");

    // A good free pushes exactly one entry onto the stack.
    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && (r_func == sha_pkg::FUNC_FREE) &&
         (n_result.status == sha_pkg::ST_OK))
        |=> (r_free_depth == $past(r_free_depth) + 1'b1))
        else $error("good free did not grow the free stack");
`endif

endmodule

[tb/sv/slot_pool_tb_pkg.sv]
`timescale 1ns / 100ps

package slot_pool_tb_pkg;

    import sha_pkg::*;

    localparam int unsigned POOL_SLOTS = 1024;

    // The block decodes this request kind as "do nothing".
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int unsigned MAX_REPORTS = 10;

    // Only a few requests are ever in flight, so a small ring is plenty.
    localparam int unsigned TRACK_DEPTH = 16;

    class slot_pool_scoreboard;

        bit              in_use[POOL_SLOTS];
        logic [ID_W-1:0] recycled[POOL_SLOTS];
        int unsigned     recycled_depth;
        int unsigned     created;
        t_result         awaited[TRACK_DEPTH];
        int unsigned     rd_ptr;
        int unsigned     wr_ptr;
        int unsigned     fill;
        int unsigned     mismatches;

        function new();
            recycled_depth = 0;
            created        = 0;
            rd_ptr         = 0;
            wr_ptr         = 0;
            fill           = 0;
            mismatches     = 0;
            foreach (in_use[k]) begin
                in_use[k] = 1'b0;
            end
        endfunction

        function int unsigned pending();
            return fill;
        endfunction

        function void count_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t ns: %s", $realtime, msg);
            end
        endfunction

        // Appends one expected result behind the ones already outstanding.
        function void stash_expected(t_result want);
            if (fill == TRACK_DEPTH) begin
                count_failure("too many requests outstanding");
                return;
            end
            awaited[wr_ptr] = want;
            wr_ptr = (wr_ptr + 1) % TRACK_DEPTH;
            fill++;
        endfunction

        // Applies one accepted request to the pool state and queues the
        // result that the block must give for it.
        function void note_request(logic [1:0] kind, logic [ID_W-1:0] id);
            t_result want;
            want = '0;
            want.status = ST_OK;
            case (kind)
                FUNC_ALLOC: begin
                    if (recycled_depth > 0) begin
                        recycled_depth--;
                        want.granted_id = recycled[recycled_depth];
                        in_use[recycled[recycled_depth]] = 1'b1;
                    end else if (created < POOL_SLOTS) begin
                        want.granted_id = ID_W'(created);
                        in_use[created] = 1'b1;
                        created++;
                    end else begin
                        want.status = ST_FULL;
                    end
                end
                FUNC_FREE: begin
                    if (id < created && in_use[id] && recycled_depth < POOL_SLOTS) begin
                        in_use[id] = 1'b0;
                        recycled[recycled_depth] = id;
                        recycled_depth++;
                    end else begin
                        want.status = ST_BAD_FREE;
                    end
                end
                FUNC_QUERY: begin
                    want.is_allocated = (id < created) && in_use[id];
                end
                default: begin
                end
            endcase
            want.slot_count      = COUNT_W'(created);
            want.allocated_count = COUNT_W'(created - recycled_depth);
            stash_expected(want);
        endfunction

        function void check_result(logic [ID_W-1:0] granted_id, logic [1:0] status,
                                   logic is_allocated, logic [COUNT_W-1:0] slot_count,
                                   logic [COUNT_W-1:0] allocated_count);
            t_result want;
            if (fill == 0) begin
                count_failure("result strobe with no request outstanding");
                return;
            end
            want = awaited[rd_ptr];
            rd_ptr = (rd_ptr + 1) % TRACK_DEPTH;
            fill--;
            if (granted_id !== want.granted_id) begin
                count_failure($sformatf("granted_id: expected %0d, got %0d",
                                        want.granted_id, granted_id));
            end
            if (status !== want.status) begin
                count_failure($sformatf("status: expected %0d, got %0d",
                                        want.status, status));
            end
            if (is_allocated !== want.is_allocated) begin
                count_failure($sformatf("is_allocated: expected %0d, got %0d",
                                        want.is_allocated, is_allocated));
            end
            if (slot_count !== want.slot_count) begin
                count_failure($sformatf("slot_count: expected %0d, got %0d",
                                        want.slot_count, slot_count));
            end
            if (allocated_count !== want.allocated_count) begin
                count_failure($sformatf("allocated_count: expected %0d, got %0d",
                                        want.allocated_count, allocated_count));
            end
        endfunction

    endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

// Top level of the slot allocator testbench. Requests are driven at the
// rising clock edge, each one is applied to the scoreboard's own copy of
// the pool the moment it is accepted, and every result strobe is compared
// field by field with the oldest outstanding expectation.
module tb_top;

    import sha_pkg::*;
    import slot_pool_tb_pkg::*;

    // A stall this long with no request and no result means the block hung.
    localparam int unsigned STALL_LIMIT = 1000;

    // Number of non-ignored random requests after the directed part.
    localparam int unsigned RANDOM_REQUESTS = 1925;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_func = FUNC_ALLOC;
    logic [ID_W-1:0]    i_slot_id = '0;
    logic               busy;
    logic               o_valid;
    logic [ID_W-1:0]    o_granted_id;
    logic [1:0]         o_status;
    logic               o_is_allocated;
    logic [COUNT_W-1:0] o_slot_count;
    logic [COUNT_W-1:0] o_allocated_count;

    slot_pool_scoreboard sb = new();

    int unsigned quiet_left = 0;
    int unsigned stall_cycles = 0;

    slot_handle_allocator_unit #(
        .NUM_SLOTS(POOL_SLOTS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_slot_id        (i_slot_id),
        .o_valid          (o_valid),
        .o_granted_id     (o_granted_id),
        .o_status         (o_status),
        .o_is_allocated   (o_is_allocated),
        .o_slot_count     (o_slot_count),
        .o_allocated_count(o_allocated_count)
    );

    always #2 i_clk = ~i_clk;

    // Gap between requests. Most gaps are zero or short, a few are long,
    // and now and then a stretch of back-to-back requests is forced so
    // that the two-stage pipeline sees every overlap of reads and writes.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Tries to find a slot that is currently handed out, so that most frees
    // and queries hit live handles. If none turns up, a plain random handle
    // is returned and the request becomes noise.
    function automatic logic [ID_W-1:0] pick_live_slot();
        logic [ID_W-1:0] cand;
        cand = ID_W'($urandom_range(0, POOL_SLOTS - 1));
        if (sb.created != 0) begin
            for (int t = 0; t < 16; t++) begin
                cand = ID_W'($urandom_range(0, sb.created - 1));
                if (sb.in_use[cand]) begin
                    break;
                end
            end
        end
        return cand;
    endfunction

    // Presents one request and holds it until the block accepts it. The
    // scoreboard is updated right here, so the next pick already sees the
    // effect of this request. When the gap is zero, start simply stays high.
    task automatic send_request(input logic [1:0] kind, input logic [ID_W-1:0] id);
        int unsigned gap;
        start     <= 1'b1;
        i_func    <= kind;
        i_slot_id <= id;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(kind, id);
        gap = pick_gap();
        if (gap != 0) begin
            // While start is low the payload carries junk that must be ignored.
            start     <= 1'b0;
            i_func    <= 2'($urandom_range(0, 3));
            i_slot_id <= ID_W'($urandom_range(0, POOL_SLOTS - 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Short directed sequence: every request kind, handle extremes, frees
    // of never-created and already-freed slots, out-of-range queries, the
    // unused request kind, and last-in first-out reuse of freed slots.
    task automatic run_directed();
        send_request(FUNC_QUERY, 10'd0);
        send_request(FUNC_FREE, 10'd0);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_UNUSED, 10'd1023);
        send_request(FUNC_ALLOC, 10'd1023);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd512);
        send_request(FUNC_QUERY, 10'd1);
        send_request(FUNC_QUERY, 10'd1023);
        send_request(FUNC_FREE, 10'd1);
        send_request(FUNC_FREE, 10'd1);
        send_request(FUNC_QUERY, 10'd1);
        send_request(FUNC_FREE, 10'd2);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE, 10'd0);
        send_request(FUNC_FREE, 10'd3);
        send_request(FUNC_UNUSED, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_QUERY, 10'h2AA);
        send_request(FUNC_QUERY, 10'h155);
    endtask

    // Random part in four phases: mostly allocates until the pool is
    // nearly used up, then allocates and queries with no frees so that the
    // full case repeats, then mostly frees so the free stack grows deep,
    // then an even mix that keeps pushing and popping the stack.
    task automatic run_random(input int unsigned target);
        int unsigned    counted;
        int unsigned    roll;
        int unsigned    w_alloc;
        int unsigned    w_free;
        int unsigned    w_query;
        logic [1:0]     kind;
        logic [ID_W-1:0] id;
        counted = 0;
        while (counted < target) begin
            if (counted < 1200) begin
                w_alloc = 88;
                w_free  = 6;
                w_query = 4;
            end else if (counted < 1350) begin
                w_alloc = 95;
                w_free  = 0;
                w_query = 4;
            end else if (counted < 1650) begin
                w_alloc = 15;
                w_free  = 70;
                w_query = 12;
            end else begin
                w_alloc = 40;
                w_free  = 35;
                w_query = 20;
            end
            roll = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, POOL_SLOTS - 1));
            if (roll < w_alloc) begin
                kind = FUNC_ALLOC;
            end else if (roll < w_alloc + w_free) begin
                kind = FUNC_FREE;
                if ($urandom_range(0, 99) < 85) begin
                    id = pick_live_slot();
                end
            end else if (roll < w_alloc + w_free + w_query) begin
                kind = FUNC_QUERY;
                if ($urandom_range(0, 1) == 1) begin
                    id = pick_live_slot();
                end
            end else begin
                kind = FUNC_UNUSED;
            end
            send_request(kind, id);
            // The unused kind changes nothing, so it does not count as work.
            if (kind != FUNC_UNUSED) begin
                counted++;
            end
        end
    endtask

    // Result monitor. The block cannot be stalled, so every strobe is a
    // result taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_granted_id, o_status, o_is_allocated,
                            o_slot_count, o_allocated_count);
        end
    end

    // Watchdog: counts edges at which neither a request nor a result moved.
    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(RANDOM_REQUESTS);
        start <= 1'b0;
        // Drain the pipeline, then give a stray extra result time to show.
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
